@@ src/box_filter_3x3_assert.svh @@
// Assertion macros for the box filter RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef BOX_FILTER_3X3_ASSERT_SVH
`define BOX_FILTER_3X3_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BF3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold in the cycle after a condition.
`define BF3_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ src/bf3_pkg.sv @@
// Package for the 3x3 box filter: pixel and column types, register codes,
// and the constants of the divide-by-nine stage. No dependencies.
package bf3_pkg;

  localparam int PIXEL_BITS    = 16;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 13;
  localparam int CFG_WIDTH_W   = 11;
  localparam int CFG_HEIGHT_W  = 13;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int COLSUM_W      = PIXEL_BITS + 2;
  localparam int WINSUM_W      = PIXEL_BITS + 4;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

  // floor(x * DIV9_MUL / 2^DIV9_SHIFT) equals floor(x / 9) for every
  // x below 2^21, which covers a nine-pixel sum plus the rounding bias.
  localparam int                   DIV9_SHIFT = 23;
  localparam logic [WINSUM_W-1:0]  DIV9_MUL   = WINSUM_W'(932068);
  localparam logic [WINSUM_W-1:0]  ROUND_BIAS = WINSUM_W'(4);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COLSUM_W-1:0]   colsum_t;

  // One column of the 3x3 window, top row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // One entry of the line store: the two rows above the current one.
  typedef struct packed {
    pix_t two_above;
    pix_t above;
  } line_pair_t;

  // What travels with an item down the pipeline.
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } tag_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

endpackage

@@ src/bf3_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// A read of the address being written returns the old contents.
module bf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/bf3_col_cell.sv @@
// One column cell of the 3x3 window chain: holds three pixels and their sum.
// Depends on bf3_pkg for the column and sum types.
module bf3_col_cell
  import bf3_pkg::*;
(
  input  logic    clk,
  input  logic    shift,
  input  column_t col_in,
  output column_t col_out,
  output colsum_t sum
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
      sum     <= COLSUM_W'(col_in.top) + COLSUM_W'(col_in.mid) + COLSUM_W'(col_in.bot);
    end
  end

endmodule

@@ src/box_filter_3x3.sv @@
// Top level of the streaming 3x3 box filter with its APB register port.
// Depends on bf3_pkg, bf3_ram, bf3_col_cell and box_filter_3x3_assert.svh.
//
// Pixels of one frame enter in raster order, one per clock unless the result
// port stalls the pipeline, and each interior pixel leaves as the rounded mean
// of its 3x3 neighborhood while border pixels, and all pixels of a frame
// narrower or shorter than three, leave unchanged. A result is released by the
// item that arrives image_width plus one items later (two items later for a
// one-pixel-wide frame) and passes the window, sum and divide stages and the
// output register on its way to the result port; drain items flush the tail
// of the frame once its last pixel is in, and are dropped before that. The two
// previous rows live in one line-store RAM of MAX_WIDTH entries, read when a
// pixel is taken and written one stage later, with a bypass for back-to-back
// hits on one column; the window is a chain of three column cells. Every
// line-store entry that feeds a result is written earlier in the same frame,
// so the store needs no clearing after reset. Writing image_width or
// image_height starts a new frame and must happen while the pipeline is empty.
`include "box_filter_3x3_assert.svh"

module box_filter_3x3
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  input  logic                  drain,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [PIXEL_BITS-1:0] smoothed_value,
  output logic                  last_of_frame
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic                    cfg_wr;
  reg_index_t              cfg_index;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_HEIGHT_W-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Frame size in use, clamped to what the hardware supports.
  logic [EW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(image_height);
    end
  end

  // Position counters for the input side and the result side.
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;

  // Pipeline handshake
  logic v1, v2, v3;
  logic s1_fire, s2_fire, s3_fire;
  logic s2_free, s3_free, out_free;

  assign out_free = !result_valid || result_ready;
  assign s3_free  = !v3 || out_free;
  assign s3_fire  = v3 && out_free;
  assign s2_free  = !v2 || s3_free;
  assign s2_fire  = v2 && s3_free;
  assign s1_fire  = v1 && s2_free;

  assign pixel_ready = !v1 || s1_fire;

  // Stage 0: decode the incoming transaction.
  logic in_fire, tail, take, emit0, interior0, last0;
  pix_t px0;

  assign in_fire = pixel_valid && pixel_ready;
  assign tail    = in_row >= eff_h;
  // A drain before the frame's last pixel is taken and dropped.
  assign take    = in_fire && (tail || !drain);
  assign px0     = tail ? '0 : pixel_value;
  assign emit0   = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));

  assign interior0 = (out_row != '0) && ((out_row + ROW_W'(1)) < eff_h) &&
                     (out_col != '0) && ((EW'(out_col) + EW'(1)) < eff_w);
  assign last0     = (out_row == (eff_h - ROW_W'(1))) && (EW'(out_col) == (eff_w - EW'(1)));

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_wr) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (take) begin
      if ((EW'(in_col) + EW'(1)) >= eff_w) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_W'(1);
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
      if (emit0) begin
        if (last0) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if ((EW'(out_col) + EW'(1)) >= eff_w) begin
          out_col_next = '0;
          out_row_next = out_row + ROW_W'(1);
        end else begin
          out_col_next = out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Stage 1: line-store read data arrives; the column is written back and
  // pushed into the window.
  logic [COL_W-1:0]        col1;
  pix_t                    px1;
  tag_t                    tag1;
  logic                    fwd1;
  line_pair_t              fwd_pair1;
  logic [2*PIXEL_BITS-1:0] ram_rdata;
  line_pair_t              lines1;
  line_pair_t              wr_pair;
  column_t                 new_col;
  logic                    fwd_hit;

  // The RAM returns old data when the previous item writes the same column
  // in the cycle of the read, so that write is captured here instead.
  assign fwd_hit = take && s1_fire && (col1 == in_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pixel_ready) begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      col1      <= in_col;
      px1       <= px0;
      tag1      <= '{emit: emit0, interior: interior0, last: last0};
      fwd1      <= fwd_hit;
      fwd_pair1 <= wr_pair;
    end
  end

  assign lines1  = fwd1 ? fwd_pair1 : line_pair_t'(ram_rdata);
  assign wr_pair = '{two_above: lines1.above, above: px1};
  assign new_col = '{top: lines1.two_above, mid: lines1.above, bot: px1};

  bf3_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (s1_fire),
    .wr_addr(col1),
    .wr_data(wr_pair),
    .rd_en  (take),
    .rd_addr(in_col),
    .rd_data(ram_rdata)
  );

  // Window: cell 2 holds the newest column, cell 0 the oldest.
  column_t col_c1, col_c2;
  colsum_t sum_c0, sum_c1, sum_c2;

  bf3_col_cell u_cell2 (
    .clk    (clk),
    .shift  (s1_fire),
    .col_in (new_col),
    .col_out(col_c2),
    .sum    (sum_c2)
  );

  bf3_col_cell u_cell1 (
    .clk    (clk),
    .shift  (s1_fire),
    .col_in (col_c2),
    .col_out(col_c1),
    .sum    (sum_c1)
  );

  bf3_col_cell u_cell0 (
    .clk    (clk),
    .shift  (s1_fire),
    .col_in (col_c1),
    .col_out(),
    .sum    (sum_c0)
  );

  // Stage 2: the window is in place; add the three column sums.
  tag_t tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s1_fire) begin
      v2 <= tag1.emit;
    end else if (s2_fire) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      tag2 <= tag1;
    end
  end

  // Stage 3: rounded divide by nine as a multiply by the reciprocal.
  logic [WINSUM_W-1:0]   total3;
  pix_t                  center3;
  logic                  interior3, last3;
  logic [2*WINSUM_W-1:0] prod3;
  pix_t                  mean3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_free) begin
      v3 <= s2_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      total3    <= WINSUM_W'(sum_c0) + WINSUM_W'(sum_c1) + WINSUM_W'(sum_c2);
      center3   <= col_c1.mid;
      interior3 <= tag2.interior;
      last3     <= tag2.last;
    end
  end

  assign prod3 = (2*WINSUM_W)'(total3 + ROUND_BIAS) * (2*WINSUM_W)'(DIV9_MUL);
  assign mean3 = prod3[DIV9_SHIFT +: PIXEL_BITS];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s3_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      smoothed_value <= interior3 ? mean3 : center3;
      last_of_frame  <= last3;
    end
  end

  `BF3_ASSERT(a_col_in_range, (EW'(in_col) < eff_w) && (EW'(out_col) < eff_w), "column counter beyond frame width")
  `BF3_ASSERT(a_row_in_range, in_row <= (eff_h + ROW_W'(1)), "input row counter past the frame tail")
  `BF3_ASSERT_NEXT(a_last_restarts, take && emit0 && last0 && !cfg_wr, (in_col == '0) && (in_row == '0) && (out_col == '0) && (out_row == '0), "frame did not restart after its last result")

endmodule
